// File: rtl/core/trdc_pkg.sv
// Shared types, constants and width helpers of the tumor reaction-diffusion cell.
`default_nettype none

package trdc_pkg;

  localparam int CELL_W    = 48;
  localparam int VAL_W     = 16;
  localparam int CFG_W     = 32;
  localparam int IH_W      = 25;
  localparam int RATE_W    = 48;
  localparam int CFG_IDX_W = 8;
  localparam int NUM_CELLS = 7;
  localparam int NUM_FACES = 6;
  // |phi_n - phi_c| times 1/h^2
  localparam int PROD_W    = VAL_W + IH_W;
  // growth factor |1 - phi|, wide enough for the largest fraction width
  localparam int GF_W      = 25;
  localparam int GROW_W    = CFG_W + VAL_W + GF_W;
  // signed accumulator of the flux terms and growth, Q.(2*frac)
  localparam int TERM_W    = 96;
  localparam int MERGE_DEPTH = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIFF_WHITE  = 8'd0,
    REG_DIFF_GREY   = 8'd1,
    REG_GROWTH_RATE = 8'd2,
    REG_TIME_STEP   = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic [CELL_W-1:0] center_cell;
    logic [CELL_W-1:0] west_cell;
    logic [CELL_W-1:0] east_cell;
    logic [CELL_W-1:0] south_cell;
    logic [CELL_W-1:0] north_cell;
    logic [CELL_W-1:0] below_cell;
    logic [CELL_W-1:0] above_cell;
    logic [IH_W-1:0]   inv_spacing_sq;
  } cell_item_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] rate_of_change;
    logic [VAL_W-1:0]         next_density;
    logic                     rate_saturated;
  } result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     value;
  } cfg_write_t;

  // Side data that rides along a face lane.
  typedef struct packed {
    logic              zero;
    logic              thin;
    logic              up;
    logic [PROD_W-1:0] x;
  } lane_side_t;

  // Center-cell data that rides past the lanes to the merge stage.
  typedef struct packed {
    logic              empty;
    logic              gneg;
    logic [VAL_W-1:0]  phi0;
    logic [GROW_W-1:0] g;
  } center_t;

  // Width of a cell diffusivity for a given fraction width.
  function automatic int dif_width(input int f);
    return CFG_W + VAL_W + 1 - f;
  endfunction

  // Stages of one face lane: two product stages, the divider, two scale stages.
  function automatic int lane_depth(input int f);
    return dif_width(f) + 5;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/trdc_chan_if.sv
// Valid/ready channel carrying one payload type.
`default_nettype none

interface trdc_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/trdc_div.sv
// Pipelined restoring divider, one quotient bit per stage, for the face coefficient.
`default_nettype none

module trdc_div import trdc_pkg::*; #(
  parameter int F = 15,
  localparam int DW = dif_width(F),
  localparam int Q  = DW + 1,
  localparam int NW = 2 * DW + 1,
  localparam int RW = DW + 1
) (
  input  logic          clk,
  input  logic [Q-1:0]  adv,
  input  logic [NW-1:0] num,
  input  logic [RW-1:0] den,
  input  lane_side_t    side_in,
  output logic [Q-1:0]  quot,
  output lane_side_t    side_out
);

  logic [RW-1:0] rem [Q];
  logic [Q-1:0]  low [Q];
  logic [Q-1:0]  qb  [Q];
  logic [RW-1:0] dv  [Q];
  lane_side_t    sd  [Q];

  for (genvar i = 0; i < Q; i++) begin : g_step
    logic [RW-1:0] rem_in;
    logic [Q-1:0]  low_in;
    logic [Q-1:0]  q_in;
    logic [RW-1:0] den_in;
    lane_side_t    side_i;
    logic [RW:0]   trial;
    logic          fits;

    if (i == 0) begin : g_first
      // quotient fits in Q bits, so the top part of the numerator is below den
      assign rem_in = RW'(num[NW-1:Q]);
      assign low_in = num[Q-1:0];
      assign q_in   = '0;
      assign den_in = den;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign low_in = low[i-1];
      assign q_in   = qb[i-1];
      assign den_in = dv[i-1];
      assign side_i = sd[i-1];
    end

    assign trial = {rem_in, low_in[Q-1]};
    assign fits  = trial >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (adv[i]) begin
        rem[i] <= fits ? RW'(trial - {1'b0, den_in}) : trial[RW-1:0];
        low[i] <= {low_in[Q-2:0], 1'b0};
        qb[i]  <= {q_in[Q-2:0], fits};
        dv[i]  <= den_in;
        sd[i]  <= side_i;
      end
    end
  end

  assign quot     = qb[Q-1];
  assign side_out = sd[Q-1];

endmodule

`default_nettype wire

// File: rtl/core/trdc_face_lane.sv
// One face lane: harmonic-mean coefficient, thin-neighbor doubling and scaled flux term.
`default_nettype none

module trdc_face_lane import trdc_pkg::*; #(
  parameter int F = 15,
  localparam int DW = dif_width(F),
  localparam int LD = lane_depth(F)
) (
  input  logic                     clk,
  input  logic [LD-1:0]            adv,
  input  logic [DW-1:0]            dn,
  input  logic [DW-1:0]            dc,
  input  logic [PROD_W-1:0]        x,
  input  logic                     up,
  input  logic                     thin,
  output logic signed [TERM_W-1:0] term
);

  localparam int Q   = DW + 1;
  localparam int NW  = 2 * DW + 1;
  localparam int H   = DW / 2;
  localparam int HW  = DW - H;
  localparam int XL  = PROD_W / 2;
  localparam int XH  = PROD_W - XL;
  localparam int FW  = DW + 2;

  // stage 0: split product and denominator
  logic [DW+H-1:0]  pl;
  logic [DW+HW-1:0] ph;
  logic [DW:0]      s0;
  lane_side_t       sd0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pl  <= (DW+H)'(dn) * (DW+H)'(dc[H-1:0]);
      ph  <= (DW+HW)'(dn) * (DW+HW)'(dc[DW-1:H]);
      s0  <= (DW+1)'(dn) + (DW+1)'(dc);
      sd0 <= '{zero: 1'b0, thin: thin, up: up, x: x};
    end
  end

  // stage 1: numerator 2*dn*dc
  logic [NW-1:0] num1;
  logic [DW:0]   den1;
  lane_side_t    sd1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      num1 <= {(2*DW)'({ph, {H{1'b0}}}) + (2*DW)'(pl), 1'b0};
      den1 <= s0;
      sd1  <= '{zero: (s0 == '0), thin: sd0.thin, up: sd0.up, x: sd0.x};
    end
  end

  logic [Q-1:0] quot;
  lane_side_t   sdq;

  trdc_div #(.F(F)) u_div (
    .clk      (clk),
    .adv      (adv[2 +: Q]),
    .num      (num1),
    .den      (den1),
    .side_in  (sd1),
    .quot     (quot),
    .side_out (sdq)
  );

  // M1: coefficient times |dphi|/h^2, split over two partial products
  logic [Q-1:0]     face;
  logic [FW-1:0]    fadj;
  logic [FW+XL-1:0] m_lo;
  logic [FW+XH-1:0] m_hi;
  logic             up_m;

  assign face = sdq.zero ? '0 : quot;
  assign fadj = sdq.thin ? {face, 1'b0} : {1'b0, face};

  always_ff @(posedge clk) begin
    if (adv[Q+2]) begin
      m_lo <= (FW+XL)'(fadj) * (FW+XL)'(sdq.x[XL-1:0]);
      m_hi <= (FW+XH)'(fadj) * (FW+XH)'(sdq.x[PROD_W-1:XL]);
      up_m <= sdq.up;
    end
  end

  // M2: combine, align to Q.(2*frac) and apply the sign
  logic [TERM_W-1:0] mag_t;
  logic [TERM_W-1:0] scaled;

  assign mag_t  = (TERM_W'(m_hi) << XL) + TERM_W'(m_lo);
  assign scaled = mag_t << F;

  always_ff @(posedge clk) begin
    if (adv[Q+3]) begin
      term <= up_m ? signed'(scaled) : -signed'(scaled);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/trdc_merge.sv
// Merge stage: sums the lane terms and growth, saturates the rate, forms the Euler update.
`default_nettype none

module trdc_merge import trdc_pkg::*; #(
  parameter int F = 15
) (
  input  logic                     clk,
  input  logic [MERGE_DEPTH-1:0]   adv,
  input  logic signed [TERM_W-1:0] term [NUM_FACES],
  input  center_t                  ctr,
  input  logic [CFG_W-1:0]         time_step,
  output result_t                  res
);

  localparam int HALF = RATE_W / 2;
  localparam int PW   = CFG_W + RATE_W;
  localparam int SW   = PW + 1;
  localparam int SH   = RATE_W - F;
  localparam logic [TERM_W-1:0] POS_LIM = (TERM_W'(1) << (RATE_W - 1)) - TERM_W'(1);
  localparam logic [TERM_W-1:0] NEG_LIM = TERM_W'(1) << (RATE_W - 1);
  localparam logic [SW-1:0]     ONE     = SW'(1) << F;

  // stage 0: first level of the adder tree
  logic signed [TERM_W-1:0] a0, b0, c0, g0;
  center_t                  ct0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      a0  <= term[0] + term[1];
      b0  <= term[2] + term[3];
      c0  <= term[4] + term[5];
      g0  <= ctr.gneg ? -signed'(TERM_W'(ctr.g)) : signed'(TERM_W'(ctr.g));
      ct0 <= ctr;
    end
  end

  // stage 1
  logic signed [TERM_W-1:0] ab1, cg1;
  logic                     empty1;
  logic [VAL_W-1:0]         phi1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      ab1    <= a0 + b0;
      cg1    <= c0 + g0;
      empty1 <= ct0.empty;
      phi1   <= ct0.phi0;
    end
  end

  // stage 2
  logic signed [TERM_W-1:0] tot2;
  logic                     empty2;
  logic [VAL_W-1:0]         phi2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      tot2   <= ab1 + cg1;
      empty2 <= empty1;
      phi2   <= phi1;
    end
  end

  // stage 3: magnitude, truncated toward zero
  logic [TERM_W-1:0] abs2;
  logic [TERM_W-1:0] mag3;
  logic              neg3, empty3;
  logic [VAL_W-1:0]  phi3;

  assign abs2 = tot2[TERM_W-1] ? TERM_W'(-tot2) : TERM_W'(tot2);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      mag3   <= abs2 >> (2 * F);
      neg3   <= tot2[TERM_W-1];
      empty3 <= empty2;
      phi3   <= phi2;
    end
  end

  // stage 4: saturate
  logic [RATE_W-1:0] rmag_c;
  logic              sat_c;
  logic [RATE_W-1:0] rmag4;
  logic              rneg4, sat4;
  logic [VAL_W-1:0]  phi4;

  always_comb begin
    rmag_c = RATE_W'(mag3);
    sat_c  = 1'b0;
    if (empty3) begin
      rmag_c = '0;
    end else if (!neg3 && mag3 > POS_LIM) begin
      rmag_c = RATE_W'(POS_LIM);
      sat_c  = 1'b1;
    end else if (neg3 && mag3 > NEG_LIM) begin
      rmag_c = RATE_W'(NEG_LIM);
      sat_c  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      rmag4 <= rmag_c;
      rneg4 <= neg3 && !empty3 && (rmag_c != '0);
      sat4  <= sat_c;
      phi4  <= phi3;
    end
  end

  // stage 5: time_step * |rate| in two halves, signed rate
  logic [CFG_W+HALF-1:0] pa5, pb5;
  logic [RATE_W-1:0]     rate5;
  logic                  rneg5, sat5;
  logic [VAL_W-1:0]      phi5;

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      pa5   <= (CFG_W+HALF)'(time_step) * (CFG_W+HALF)'(rmag4[HALF-1:0]);
      pb5   <= (CFG_W+HALF)'(time_step) * (CFG_W+HALF)'(rmag4[RATE_W-1:HALF]);
      rate5 <= rneg4 ? (RATE_W'(0) - rmag4) : rmag4;
      rneg5 <= rneg4;
      sat5  <= sat4;
      phi5  <= phi4;
    end
  end

  // stage 6
  logic [SW-1:0]     prod6, base6;
  logic [RATE_W-1:0] rate6;
  logic              rneg6, sat6;

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      prod6 <= SW'(pa5) + (SW'(pb5) << HALF);
      base6 <= SW'(phi5) << SH;
      rate6 <= rate5;
      rneg6 <= rneg5;
      sat6  <= sat5;
    end
  end

  // stage 7: Euler step, flag underflow below zero
  logic [SW-1:0]     sum7;
  logic              under7, sat7;
  logic [RATE_W-1:0] rate7;

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      sum7   <= rneg6 ? (base6 - prod6) : (base6 + prod6);
      under7 <= rneg6 && (base6 < prod6);
      rate7  <= rate6;
      sat7   <= sat6;
    end
  end

  // stage 8: clamp to [0, 1] and register the result
  logic [SW-1:0] nd_c;

  always_comb begin
    nd_c = under7 ? '0 : (sum7 >> SH);
    if (nd_c > ONE) begin
      nd_c = ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      res.rate_of_change <= signed'(rate7);
      res.next_density   <= nd_c[VAL_W-1:0];
      res.rate_saturated <= sat7;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/tumor_reaction_diffusion_cell.sv
// Top level of the tumor reaction-diffusion cell update.
`default_nettype none

// Takes one stencil item (center cell, six face neighbors, 1/h^2) per clock and
// returns dphidt in signed Q23.24 with a saturation flag and the clamped Euler
// update of phi. Six face lanes run side by side, each forming the harmonic-mean
// face coefficient with a pipelined divider that resolves one quotient bit per
// stage; a merge stage sums the flux terms with the logistic growth. Throughput
// is one item per clock unless the full pipeline is stalled at the output; the
// divider depth is 50 - VALUE_FRAC_BITS stages. Each pipeline stage holds only
// while it and every later stage are full and the output is stalled, so the
// input keeps flowing into empty stages while a result waits at the output.
// Configuration writes are taken every cycle and must only be issued while the
// pipeline is empty.

module tumor_reaction_diffusion_cell import trdc_pkg::*; #(
  parameter int VALUE_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  trdc_chan_if.sink   cell_in,
  trdc_chan_if.source result_out,
  trdc_chan_if.sink   cfg
);

  localparam int F     = VALUE_FRAC_BITS;
  localparam int DW    = dif_width(F);
  localparam int LD    = lane_depth(F);
  localparam int FRONT = 3;
  localparam int NS    = FRONT + LD + MERGE_DEPTH;
  localparam int MW    = CFG_W + VAL_W;
  localparam int GH    = MW / 2;
  localparam logic [GF_W-1:0] ONE = GF_W'(1) << F;

  // configuration registers
  logic [CFG_W-1:0] diff_white, diff_grey, growth_rate, time_step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_white  <= '0;
      diff_grey   <= '0;
      growth_rate <= '0;
      time_step   <= '0;
    end else if (cfg.valid) begin
      case (cfg.data.index)
        REG_DIFF_WHITE:  diff_white  <= cfg.data.value;
        REG_DIFF_GREY:   diff_grey   <= cfg.data.value;
        REG_GROWTH_RATE: growth_rate <= cfg.data.value;
        REG_TIME_STEP:   time_step   <= cfg.data.value;
        default: ;
      endcase
    end
  end

  // pipeline occupancy; a stage advances when the output is ready or it or any later stage has room
  logic [NS-1:0] vld;
  logic [NS:0]   adv;

  always_comb begin
    adv[NS] = result_out.ready;
    for (int i = 0; i < NS; i++) begin
      adv[i] = result_out.ready || ((~vld >> i) != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= cell_in.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign cell_in.ready    = adv[0];
  assign result_out.valid = vld[NS-1];

  // stage 0: capture the stencil
  logic [CELL_W-1:0] c0 [NUM_CELLS];
  logic [IH_W-1:0]   ih0;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      c0[0] <= cell_in.data.center_cell;
      c0[1] <= cell_in.data.west_cell;
      c0[2] <= cell_in.data.east_cell;
      c0[3] <= cell_in.data.south_cell;
      c0[4] <= cell_in.data.north_cell;
      c0[5] <= cell_in.data.below_cell;
      c0[6] <= cell_in.data.above_cell;
      ih0   <= cell_in.data.inv_spacing_sq;
    end
  end

  logic [VAL_W-1:0] phi [NUM_CELLS];
  logic [VAL_W-1:0] wh  [NUM_CELLS];
  logic [VAL_W-1:0] gr  [NUM_CELLS];

  always_comb begin
    for (int k = 0; k < NUM_CELLS; k++) begin
      phi[k] = c0[k][2*VAL_W +: VAL_W];
      wh[k]  = c0[k][VAL_W +: VAL_W];
      gr[k]  = c0[k][0 +: VAL_W];
    end
  end

  // stage 1: matter products, phi differences, thin flags, growth prefactor
  logic [MW-1:0]    pw1 [NUM_CELLS];
  logic [MW-1:0]    pg1 [NUM_CELLS];
  logic [VAL_W-1:0] d1  [NUM_FACES];
  logic [NUM_FACES-1:0] up1, thin1;
  logic [MW-1:0]    rp1;
  logic [GF_W-1:0]  gf1;
  logic             gneg1, empty1;
  logic [VAL_W-1:0] phi1;
  logic [IH_W-1:0]  ih1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      for (int k = 0; k < NUM_CELLS; k++) begin
        pw1[k] <= MW'(wh[k]) * MW'(diff_white);
        pg1[k] <= MW'(gr[k]) * MW'(diff_grey);
      end
      for (int k = 0; k < NUM_FACES; k++) begin
        up1[k]   <= phi[k+1] >= phi[0];
        d1[k]    <= (phi[k+1] >= phi[0]) ? (phi[k+1] - phi[0]) : (phi[0] - phi[k+1]);
        thin1[k] <= (GF_W'(4'd10) * (GF_W'(phi[k+1]) + GF_W'(wh[k+1]) + GF_W'(gr[k+1])))
                    < ONE;
      end
      rp1    <= MW'(growth_rate) * MW'(phi[0]);
      gneg1  <= GF_W'(phi[0]) > ONE;
      gf1    <= (GF_W'(phi[0]) > ONE) ? (GF_W'(phi[0]) - ONE) : (ONE - GF_W'(phi[0]));
      empty1 <= c0[0] == '0;
      phi1   <= phi[0];
      ih1    <= ih0;
    end
  end

  // stage 2: diffusivities, scaled differences, growth term in two halves
  logic [DW-1:0]     dif2 [NUM_CELLS];
  logic [PROD_W-1:0] x2   [NUM_FACES];
  logic [NUM_FACES-1:0] up2, thin2;
  logic [GH+GF_W-1:0]      gl2;
  logic [MW-GH+GF_W-1:0]   gh2;
  logic              empty2, gneg2;
  logic [VAL_W-1:0]  phi2;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      for (int k = 0; k < NUM_CELLS; k++) begin
        dif2[k] <= DW'(((MW+1)'(pw1[k]) + (MW+1)'(pg1[k])) >> F);
      end
      for (int k = 0; k < NUM_FACES; k++) begin
        x2[k] <= PROD_W'(d1[k]) * PROD_W'(ih1);
      end
      up2    <= up1;
      thin2  <= thin1;
      gl2    <= (GH+GF_W)'(rp1[GH-1:0]) * (GH+GF_W)'(gf1);
      gh2    <= (MW-GH+GF_W)'(rp1[MW-1:GH]) * (MW-GH+GF_W)'(gf1);
      empty2 <= empty1;
      gneg2  <= gneg1;
      phi2   <= phi1;
    end
  end

  // face lanes; a thin neighbor doubles the opposite face
  logic signed [TERM_W-1:0] term [NUM_FACES];

  for (genvar k = 0; k < NUM_FACES; k++) begin : g_lane
    trdc_face_lane #(.F(F)) u_lane (
      .clk  (clk),
      .adv  (adv[FRONT +: LD]),
      .dn   (dif2[k+1]),
      .dc   (dif2[0]),
      .x    (x2[k]),
      .up   (up2[k]),
      .thin (thin2[k ^ 1]),
      .term (term[k])
    );
  end

  // center data waits alongside the lanes; combine the growth halves on entry
  center_t ctr_d [LD];

  always_ff @(posedge clk) begin
    if (adv[FRONT]) begin
      ctr_d[0] <= '{empty: empty2, gneg: gneg2, phi0: phi2,
                    g: (GROW_W'(gh2) << GH) + GROW_W'(gl2)};
    end
    for (int i = 1; i < LD; i++) begin
      if (adv[FRONT+i]) begin
        ctr_d[i] <= ctr_d[i-1];
      end
    end
  end

  result_t res;

  trdc_merge #(.F(F)) u_merge (
    .clk       (clk),
    .adv       (adv[FRONT+LD +: MERGE_DEPTH]),
    .term      (term),
    .ctr       (ctr_d[LD-1]),
    .time_step (time_step),
    .res       (res)
  );

  assign result_out.data = res;

`ifndef SYNTHESIS
  // input only backs up when the full pipeline is stalled at the output
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !cell_in.ready |-> result_out.valid && !result_out.ready)
    else $error("input stalled while output free");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.data.rate_saturated |->
      (result_out.data.rate_of_change == {1'b0, {(RATE_W-1){1'b1}}}) ||
      (result_out.data.rate_of_change == {1'b1, {(RATE_W-1){1'b0}}}))
    else $error("saturation flag without limit value");

  a_sat_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.data.rate_of_change == '0 |->
      !result_out.data.rate_saturated)
    else $error("zero rate flagged as saturated");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_out.valid)
    else $error("result valid after reset");
`endif

endmodule

`default_nettype wire

// File: test/tumor_reaction_diffusion_cell_tb.sv
// Self-checking testbench of the tumor reaction-diffusion cell: directed table, then random phases.
`default_nettype none

module tumor_reaction_diffusion_cell_tb;
  import trdc_pkg::*;

  localparam int FRAC        = 15;
  localparam int ONE         = 1 << FRAC;
  localparam int LATENCY     = 66 - FRAC;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 110;
  localparam int ITEM_W      = $bits(cell_item_t);

  typedef struct {
    cell_item_t item;
    int         cfg_set;   // which configuration the row runs under
    bit         typed;     // expected result given in the row
    result_t    want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trdc_chan_if #(.payload_t(cell_item_t)) cell_ch ();
  trdc_chan_if #(.payload_t(result_t))    res_ch ();
  trdc_chan_if #(.payload_t(cfg_write_t)) cfg_ch ();

  tumor_reaction_diffusion_cell #(.VALUE_FRAC_BITS(FRAC)) DUT (
    .clk        (clk),
    .rst        (rst),
    .cell_in    (cell_ch.sink),
    .result_out (res_ch.source),
    .cfg        (cfg_ch.sink)
  );

  // Shadow of the configuration registers.
  logic [CFG_W-1:0] sh_diff_white, sh_diff_grey, sh_growth, sh_step;

  result_t pending_results[$];
  int      mismatches   = 0;
  int      checked      = 0;
  int      items_sent   = 0;
  int      cfg_changes  = 0;
  int      cycles       = 0;
  bit      hold_request = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    cell_ch.valid = 1'b0;
    cell_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    res_ch.ready  = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s: got %h, expected %h (result %0d)", what, got, want, checked);
    mismatches++;
  endtask

  function automatic logic [CELL_W-1:0] pack_cell(input int phi, input int wh, input int gr);
    return {phi[15:0], wh[15:0], gr[15:0]};
  endfunction

  // Expected rate, updated density and clip flag of one stencil item.
  function automatic result_t predict_cell(input cell_item_t it);
    logic [CELL_W-1:0] cells[7];
    logic [15:0]  phi[7], wh[7], gr[7];
    logic [63:0]  dif[7], face[6];
    bit           thin[6];
    logic [63:0]  s, d, rmag;
    logic [127:0] pos, neg, mag, num, t, rp, base, prod, nd, lim;
    int           total;
    bit           rneg, sat;
    result_t      r;
    cells = '{it.center_cell, it.west_cell, it.east_cell, it.south_cell,
              it.north_cell, it.below_cell, it.above_cell};
    for (int k = 0; k < 7; k++) begin
      phi[k] = cells[k][47:32];
      wh[k]  = cells[k][31:16];
      gr[k]  = cells[k][15:0];
      dif[k] = (64'(wh[k]) * 64'(sh_diff_white) + 64'(gr[k]) * 64'(sh_diff_grey)) >> FRAC;
    end
    rmag = 0;
    rneg = 1'b0;
    sat  = 1'b0;
    if ((phi[0] | wh[0] | gr[0]) != 0) begin
      for (int k = 0; k < 6; k++) begin
        s = dif[k+1] + dif[0];
        num = (128'(dif[k+1]) * 128'(dif[0])) << 1;
        face[k] = (s == 0) ? 64'd0 : 64'(num / 128'(s));
        total = int'(phi[k+1]) + int'(wh[k+1]) + int'(gr[k+1]);
        thin[k] = (10 * total) < ONE;
      end
      // a thin neighbor doubles the coefficient of the opposite face
      for (int k = 0; k < 6; k++)
        if (thin[k]) face[k ^ 1] = face[k ^ 1] << 1;
      pos = 0;
      neg = 0;
      for (int k = 0; k < 6; k++) begin
        d = (phi[k+1] >= phi[0]) ? 64'(phi[k+1] - phi[0]) : 64'(phi[0] - phi[k+1]);
        t = (128'(face[k] * d) * 128'(it.inv_spacing_sq)) << FRAC;
        if (phi[k+1] >= phi[0]) pos = pos + t;
        else neg = neg + t;
      end
      rp = 128'(sh_growth) * 128'(phi[0]);
      if (phi[0] <= ONE) pos = pos + rp * 128'(ONE - phi[0]);
      else neg = neg + rp * 128'(phi[0] - ONE);
      if (pos < neg) begin
        rneg = 1'b1;
        mag = neg - pos;
      end else begin
        mag = pos - neg;
      end
      mag = mag >> (2 * FRAC);
      lim = rneg ? (128'd1 << 47) : ((128'd1 << 47) - 1);
      if (mag > lim) begin
        rmag = 64'(lim);
        sat = 1'b1;
      end else begin
        rmag = 64'(mag);
      end
      if (rmag == 0) rneg = 1'b0;
    end
    base = 128'(phi[0]) << (48 - FRAC);
    prod = 128'(sh_step) * 128'(rmag);
    if (rneg) nd = (base < prod) ? 128'd0 : (base - prod) >> (48 - FRAC);
    else nd = (base + prod) >> (48 - FRAC);
    if (nd > ONE) nd = ONE;
    r.rate_of_change = rneg ? -rmag[47:0] : rmag[47:0];
    r.next_density   = nd[15:0];
    r.rate_saturated = sat;
    return r;
  endfunction

  // Result side: random stalls, plus one long hold when asked.
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      if (hold_request) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      stall = $urandom_range(0, 3);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(res_ch.data), 64'd0);
      end else begin
        want = pending_results.pop_front();
        if (res_ch.data.rate_of_change !== want.rate_of_change)
          report_mismatch("rate_of_change", 64'(res_ch.data.rate_of_change),
                          64'(want.rate_of_change));
        if (res_ch.data.next_density !== want.next_density)
          report_mismatch("next_density", 64'(res_ch.data.next_density),
                          64'(want.next_density));
        if (res_ch.data.rate_saturated !== want.rate_saturated)
          report_mismatch("rate_saturated", 64'(res_ch.data.rate_saturated),
                          64'(want.rate_saturated));
      end
      checked <= checked + 1;
    end
  end

  task automatic send_cell(input cell_item_t it, input bit typed, input result_t want);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      cell_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cell_ch.valid <= 1'b1;
    cell_ch.data  <= it;
    do @(posedge clk); while (!cell_ch.ready);
    pending_results.push_back(typed ? want : predict_cell(it));
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      cfg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{index: idx, value: value};
    do @(posedge clk); while (!cfg_ch.ready);
    case (reg_idx_t'(idx))
      REG_DIFF_WHITE:  sh_diff_white = value;
      REG_DIFF_GREY:   sh_diff_grey  = value;
      REG_GROWTH_RATE: sh_growth     = value;
      REG_TIME_STEP:   sh_step       = value;
      default: ;
    endcase
  endtask

  // Drop valid, let the pipeline empty, then load a new setting.
  task automatic load_config(input logic [CFG_W-1:0] dw, input logic [CFG_W-1:0] dg,
                             input logic [CFG_W-1:0] gw, input logic [CFG_W-1:0] ts);
    cell_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    write_reg(REG_DIFF_WHITE, dw);
    write_reg(REG_DIFF_GREY, dg);
    // unmapped index must be ignored
    write_reg(($urandom_range(0, 1) != 0) ? 8'hFF : 8'($urandom_range(4, 255)), $urandom);
    write_reg(REG_GROWTH_RATE, gw);
    write_reg(REG_TIME_STEP, ts);
    cfg_ch.valid <= 1'b0;
    cfg_changes++;
  endtask

  function automatic logic [CFG_W-1:0] rand_reg();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'd0;
      default: return 32'($urandom_range(0, 32'h0400_0000));
    endcase
  endfunction

  function automatic logic [CELL_W-1:0] rand_tissue();
    int phi, wh, gr;
    phi = $urandom_range(0, ONE);
    wh  = $urandom_range(0, ONE);
    gr  = $urandom_range(0, ONE - wh);
    return pack_cell(phi, wh, gr);
  endfunction

  function automatic logic [CELL_W-1:0] rand_thin();
    return pack_cell($urandom_range(0, 1100), $urandom_range(0, 1100), $urandom_range(0, 1100));
  endfunction

  function automatic cell_item_t rand_item();
    cell_item_t it;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom});
    end else begin
      it.center_cell = rand_tissue();
      it.west_cell   = rand_tissue();
      it.east_cell   = rand_tissue();
      it.south_cell  = rand_tissue();
      it.north_cell  = rand_tissue();
      it.below_cell  = rand_tissue();
      it.above_cell  = rand_tissue();
      if (mode <= 3) begin
        if ($urandom_range(0, 1)) it.west_cell  = rand_thin();
        if ($urandom_range(0, 1)) it.north_cell = rand_thin();
        if ($urandom_range(0, 1)) it.above_cell = rand_thin();
        if ($urandom_range(0, 2) == 0) it.south_cell = '0;
      end
      if (mode == 4) it.center_cell = ($urandom_range(0, 1) != 0) ? '0 : rand_thin();
      it.inv_spacing_sq = IH_W'($urandom_range(1, 64));
    end
    if ($urandom_range(0, 7) == 0) it.inv_spacing_sq = IH_W'($urandom);
    return it;
  endfunction

  stim_row_t directed[$];

  initial begin
    stim_row_t  row;
    cell_item_t it;
    int         cur_set;
    logic [CELL_W-1:0] full, mid, hi_phi;
    full   = {CELL_W{1'b1}};
    mid    = pack_cell(ONE / 2, ONE / 2, ONE / 4);
    hi_phi = pack_cell(16'hF000, 1000, 2000);

    // reset setting: no diffusion, no growth, density passes through clamped
    row = '{item: '0, cfg_set: 0, typed: 1, want: '{rate_of_change: 0, next_density: 0,
            rate_saturated: 0}};
    directed.push_back(row);
    row.item = {full, full, full, full, full, full, full, {IH_W{1'b1}}};
    row.want = '{rate_of_change: 0, next_density: 16'(ONE), rate_saturated: 0};
    directed.push_back(row);
    row.item = '{center_cell: pack_cell(16'h4000, 0, 0), inv_spacing_sq: 1, default: '0};
    row.want = '{rate_of_change: 0, next_density: 16'h4000, rate_saturated: 0};
    directed.push_back(row);

    // every register at its top value
    row = '{item: '0, cfg_set: 1, typed: 1, want: '0};
    row.item = '{center_cell: '0, inv_spacing_sq: {IH_W{1'b1}}, default: full};
    directed.push_back(row);
    row.typed = 0;
    row.item = {full, full, full, full, full, full, full, {IH_W{1'b1}}};
    directed.push_back(row);
    row.item = {mid, {CELL_W{1'b0}}, full, {CELL_W{1'b0}}, full, {CELL_W{1'b0}}, full,
                IH_W'(25'h100_0000)};
    directed.push_back(row);
    row.item = {full, mid, mid, mid, mid, mid, mid, IH_W'(0)};
    directed.push_back(row);
    row.item = {hi_phi, mid, mid, mid, mid, mid, mid, IH_W'(1)};
    directed.push_back(row);

    // moderate tissue setting
    row = '{item: '0, cfg_set: 2, typed: 0, want: '0};
    row.item = {mid, pack_cell(ONE, ONE / 2, 0), pack_cell(0, ONE / 2, ONE / 2), mid, mid,
                mid, mid, IH_W'(16)};
    directed.push_back(row);
    row.item = {mid, pack_cell(100, 100, 100), mid, mid, pack_cell(0, 0, 0), mid,
                pack_cell(1092, 1092, 1092), IH_W'(4)};
    directed.push_back(row);
    row.item = {mid, pack_cell(1093, 1092, 1092), mid, mid, mid, pack_cell(1092, 1092, 1091),
                mid, IH_W'(4)};
    directed.push_back(row);
    row.item = {hi_phi, mid, mid, mid, mid, mid, mid, IH_W'(8)};
    directed.push_back(row);
    row.item = {pack_cell(0, ONE, 0), full, full, {CELL_W{1'b0}}, {CELL_W{1'b0}}, mid, mid,
                IH_W'(25'h100_0000)};
    directed.push_back(row);
    row.item = {pack_cell(ONE, 0, ONE), mid, mid, mid, mid, mid, mid, IH_W'(0)};
    directed.push_back(row);
    row.typed = 1;
    row.item = '{inv_spacing_sq: {IH_W{1'b1}}, center_cell: '0, default: mid};
    row.want = '0;
    directed.push_back(row);

    sh_diff_white = '0;
    sh_diff_grey  = '0;
    sh_growth     = '0;
    sh_step       = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_set = 0;
    foreach (directed[i]) begin
      if (directed[i].cfg_set != cur_set) begin
        cur_set = directed[i].cfg_set;
        if (cur_set == 1) load_config('1, '1, '1, '1);
        else load_config(32'h0100_0000, 32'h0020_0000, 32'h0080_0000, 32'h0001_0000);
      end
      send_cell(directed[i].item, directed[i].typed, directed[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 0) load_config('0, '0, '0, '0);
      else if (p == 1) load_config('1, '1, '1, '1);
      else load_config(rand_reg(), rand_reg(), rand_reg(), rand_reg());
      // stall the output for a long stretch while items keep coming
      if (p == 3) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it = rand_item();
        send_cell(it, 1'b0, '0);
      end
    end
    cell_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
    $display("covered %0d stencil items over %0d register settings; %0d results compared",
             items_sent, cfg_changes, checked);
    $display("%0d field mismatches", mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
